// ===== rtl/tpsc_pkg.sv =====
// ============================================================================
// tpsc_pkg
// Shared types and constants for the tile/sprite pixel compositor.
// ============================================================================
package tpsc_pkg;

    typedef enum logic [2:0] {
        ACT_RENDER      = 3'd0,
        ACT_SHIFT       = 3'd1,
        ACT_LOAD_TILE   = 3'd2,
        ACT_LOAD_SPRITE = 3'd3,
        ACT_ARM         = 3'd4
    } action_t;

    // APB register map, index = paddr[4:2]
    localparam int          APB_ADDR_W = 5;
    localparam int          APB_DATA_W = 32;
    localparam logic [2:0]  REG_BG_ENABLE          = 3'd0;
    localparam logic [2:0]  REG_SPRITE_ENABLE      = 3'd1;
    localparam logic [2:0]  REG_BG_LEFT_ENABLE     = 3'd2;
    localparam logic [2:0]  REG_SPRITE_LEFT_ENABLE = 3'd3;
    localparam logic [2:0]  REG_EMPHASIS           = 3'd4;

    localparam logic [6:0]  EMPTY_ID        = 7'd64;
    localparam logic [13:0] PALETTE_BASE    = 14'h3F00;
    localparam logic [7:0]  LEFT_EDGE_COLS  = 8'd8;
    localparam logic [7:0]  LAST_DOT        = 8'd255;

    // One input beat as held in the input register
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  fine_x;
        logic [7:0]  dot_x;
        logic        pixel_visible;
        logic [2:0]  slot;
        logic [6:0]  sprite_id;
        logic [7:0]  sprite_attr;
        logic [7:0]  sprite_x;
        logic [7:0]  pattern_lo;
        logic [7:0]  pattern_hi;
        logic [1:0]  tile_palette;
        logic [13:0] vram_address;
    } item_t;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/tile_pixel_sprite_compositor_top.sv =====
// ============================================================================
// tile_pixel_sprite_compositor_top
// Per-dot background/sprite multiplexer producing palette addresses.
// ============================================================================
// One beat per clock: a beat is captured in the input register, then the
// background shifters and sprite slots are read and updated and the result
// lands in the output register, and a new beat can enter every cycle while
// m_ready is high. Only render beats with
// pixel_visible set produce a result; when the output register is full and
// not taken, a visible render beat waits in the input register, other beats
// flow on. Configuration is written through the APB port (byte address
// 4*index).
module tile_pixel_sprite_compositor_top #(
    parameter int SPRITE_SLOTS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_action,
    input  logic [2:0]                       s_fine_x,
    input  logic [7:0]                       s_dot_x,
    input  logic                             s_pixel_visible,
    input  logic [2:0]                       s_slot,
    input  logic [6:0]                       s_sprite_id,
    input  logic [7:0]                       s_sprite_attr,
    input  logic [7:0]                       s_sprite_x,
    input  logic [7:0]                       s_pattern_lo,
    input  logic [7:0]                       s_pattern_hi,
    input  logic [1:0]                       s_tile_palette,
    input  logic [13:0]                      s_vram_address,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [4:0]                       m_palette_address,
    output logic [2:0]                       m_emphasis_bits,
    output logic                             m_sprite_zero_hit,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tpsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tpsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tpsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import tpsc_pkg::*;

    // configuration registers
    logic       bg_enable_reg, sprite_enable_reg, bg_left_enable_reg, sprite_left_enable_reg;
    logic [2:0] emphasis_reg;
    logic       cfg_write;
    logic [2:0] cfg_index;

    // input register
    item_t      s1_reg;
    logic       s1_valid_reg;

    // background shifters
    logic [15:0] bg_plane_lo_reg, bg_plane_hi_reg, bg_attr_lo_reg, bg_attr_hi_reg;
    logic [15:0] bg_plane_lo_next, bg_plane_hi_next, bg_attr_lo_next, bg_attr_hi_next;

    // sprite slots
    logic [6:0] slot_id_reg        [SPRITE_SLOTS];
    logic [7:0] slot_attr_reg      [SPRITE_SLOTS];
    logic [7:0] slot_countdown_reg [SPRITE_SLOTS];
    logic [7:0] slot_plane_lo_reg  [SPRITE_SLOTS];
    logic [7:0] slot_plane_hi_reg  [SPRITE_SLOTS];
    logic       slot_counting_reg  [SPRITE_SLOTS];
    logic [6:0] slot_id_next        [SPRITE_SLOTS];
    logic [7:0] slot_attr_next      [SPRITE_SLOTS];
    logic [7:0] slot_countdown_next [SPRITE_SLOTS];
    logic [7:0] slot_plane_lo_next  [SPRITE_SLOTS];
    logic [7:0] slot_plane_hi_next  [SPRITE_SLOTS];
    logic       slot_counting_next  [SPRITE_SLOTS];

    // output register
    logic       m_valid_reg;
    logic [4:0] m_palette_address_reg;
    logic [2:0] m_emphasis_bits_reg;
    logic       m_sprite_zero_hit_reg;

    // datapath
    logic       render_on;
    logic       left_edge;
    logic [3:0] bg_sel;
    logic [3:0] bg_pix;
    logic [3:0] bg_pal;
    logic       produces;
    logic       out_free;
    logic       advance;
    logic [1:0] sp;
    logic       obj_found;
    logic [3:0] obj_color;
    logic       obj_behind;
    logic       hit;
    logic [4:0] pix_out;
    logic [4:0] addr_out;

    // ------------------------------------------------------------------
    // APB configuration
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_enable_reg          <= 1'b0;
            sprite_enable_reg      <= 1'b0;
            bg_left_enable_reg     <= 1'b0;
            sprite_left_enable_reg <= 1'b0;
            emphasis_reg           <= 3'd0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_BG_ENABLE:          bg_enable_reg          <= pwdata[0];
                REG_SPRITE_ENABLE:      sprite_enable_reg      <= pwdata[0];
                REG_BG_LEFT_ENABLE:     bg_left_enable_reg     <= pwdata[0];
                REG_SPRITE_LEFT_ENABLE: sprite_left_enable_reg <= pwdata[0];
                REG_EMPHASIS:           emphasis_reg           <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_index)
            REG_BG_ENABLE:          prdata[0]   = bg_enable_reg;
            REG_SPRITE_ENABLE:      prdata[0]   = sprite_enable_reg;
            REG_BG_LEFT_ENABLE:     prdata[0]   = bg_left_enable_reg;
            REG_SPRITE_LEFT_ENABLE: prdata[0]   = sprite_left_enable_reg;
            REG_EMPHASIS:           prdata[2:0] = emphasis_reg;
            default:                prdata      = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign render_on = bg_enable_reg || sprite_enable_reg;
    assign produces  = (s1_reg.action == ACT_RENDER) && s1_reg.pixel_visible;
    assign out_free  = !m_valid_reg || m_ready;
    // beats without a result never wait on the output side
    assign advance   = s1_valid_reg && (!produces || out_free);
    assign s_ready   = !s1_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            s1_valid_reg <= 1'b1;
        end else if (advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_reg <= '{action:        s_action,
                        fine_x:        s_fine_x,
                        dot_x:         s_dot_x,
                        pixel_visible: s_pixel_visible,
                        slot:          s_slot,
                        sprite_id:     s_sprite_id,
                        sprite_attr:   s_sprite_attr,
                        sprite_x:      s_sprite_x,
                        pattern_lo:    s_pattern_lo,
                        pattern_hi:    s_pattern_hi,
                        tile_palette:  s_tile_palette,
                        vram_address:  s_vram_address};
        end
    end

    // ------------------------------------------------------------------
    // Pixel datapath and state update
    // ------------------------------------------------------------------
    assign left_edge = s1_reg.dot_x < LEFT_EDGE_COLS;
    // bit 15 - fine_x
    assign bg_sel    = {1'b1, ~s1_reg.fine_x};
    assign bg_pix    = {bg_attr_hi_reg[bg_sel], bg_attr_lo_reg[bg_sel],
                        bg_plane_hi_reg[bg_sel], bg_plane_lo_reg[bg_sel]};

    always_comb begin
        bg_pal = 4'd0;
        if (render_on && bg_enable_reg && (bg_pix[1:0] != 2'd0)
            && !(!bg_left_enable_reg && left_edge)) begin
            bg_pal = bg_pix;
        end
    end

    always_comb begin
        bg_plane_lo_next = bg_plane_lo_reg;
        bg_plane_hi_next = bg_plane_hi_reg;
        bg_attr_lo_next  = bg_attr_lo_reg;
        bg_attr_hi_next  = bg_attr_hi_reg;
        slot_id_next        = slot_id_reg;
        slot_attr_next      = slot_attr_reg;
        slot_countdown_next = slot_countdown_reg;
        slot_plane_lo_next  = slot_plane_lo_reg;
        slot_plane_hi_next  = slot_plane_hi_reg;
        slot_counting_next  = slot_counting_reg;
        sp         = 2'd0;
        obj_found  = 1'b0;
        obj_color  = 4'd0;
        obj_behind = 1'b0;
        hit        = 1'b0;

        if (advance) begin
            case (s1_reg.action)
                ACT_RENDER, ACT_SHIFT: begin
                    if (render_on) begin
                        bg_plane_lo_next = {bg_plane_lo_reg[14:0], 1'b0};
                        bg_plane_hi_next = {bg_plane_hi_reg[14:0], 1'b1};
                        bg_attr_lo_next  = {bg_attr_lo_reg[14:0], 1'b0};
                        bg_attr_hi_next  = {bg_attr_hi_reg[14:0], 1'b0};
                    end
                    if (produces) begin
                        // walk high to low so the lowest opaque slot wins
                        for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
                            if (slot_id_reg[i] != EMPTY_ID) begin
                                if (slot_counting_reg[i] && (slot_countdown_reg[i] != 8'd0)) begin
                                    slot_countdown_next[i] = slot_countdown_reg[i] - 8'd1;
                                end else begin
                                    slot_counting_next[i] = 1'b0;
                                    if (render_on) begin
                                        sp = {slot_plane_hi_reg[i][7], slot_plane_lo_reg[i][7]};
                                        slot_plane_lo_next[i] = {slot_plane_lo_reg[i][6:0], 1'b0};
                                        slot_plane_hi_next[i] = {slot_plane_hi_reg[i][6:0], 1'b0};
                                        if (sprite_enable_reg && (sp != 2'd0)
                                            && !(!sprite_left_enable_reg && left_edge)) begin
                                            if ((slot_id_reg[i] == 7'd0) && (bg_pal != 4'd0)
                                                && (s1_reg.dot_x != LAST_DOT)) begin
                                                hit = 1'b1;
                                            end
                                            obj_found  = 1'b1;
                                            obj_color  = {slot_attr_reg[i][1:0], sp};
                                            obj_behind = slot_attr_reg[i][5];
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                ACT_LOAD_TILE: begin
                    bg_plane_lo_next = {bg_plane_lo_reg[15:8], s1_reg.pattern_lo};
                    bg_plane_hi_next = {bg_plane_hi_reg[15:8], s1_reg.pattern_hi};
                    bg_attr_lo_next  = {bg_attr_lo_reg[15:8], {8{s1_reg.tile_palette[0]}}};
                    bg_attr_hi_next  = {bg_attr_hi_reg[15:8], {8{s1_reg.tile_palette[1]}}};
                end
                ACT_LOAD_SPRITE: begin
                    for (int i = 0; i < SPRITE_SLOTS; i++) begin
                        if (int'(s1_reg.slot) == i) begin
                            slot_id_next[i]        = s1_reg.sprite_id;
                            slot_attr_next[i]      = s1_reg.sprite_attr;
                            slot_countdown_next[i] = s1_reg.sprite_x;
                            slot_plane_lo_next[i]  = s1_reg.sprite_attr[6] ?
                                                     flip8(s1_reg.pattern_lo) : s1_reg.pattern_lo;
                            slot_plane_hi_next[i]  = s1_reg.sprite_attr[6] ?
                                                     flip8(s1_reg.pattern_hi) : s1_reg.pattern_hi;
                        end
                    end
                end
                ACT_ARM: begin
                    if (render_on) begin
                        for (int i = 0; i < SPRITE_SLOTS; i++) begin
                            slot_counting_next[i] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign pix_out  = (obj_found && ((bg_pal == 4'd0) || !obj_behind)) ?
                      {1'b1, obj_color} : {1'b0, bg_pal};
    // rendering off with the address in palette space shows that entry
    assign addr_out = (render_on || (s1_reg.vram_address < PALETTE_BASE)) ?
                      pix_out : s1_reg.vram_address[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_plane_lo_reg <= '0;
            bg_plane_hi_reg <= '0;
            bg_attr_lo_reg  <= '0;
            bg_attr_hi_reg  <= '0;
            for (int i = 0; i < SPRITE_SLOTS; i++) begin
                slot_id_reg[i]        <= EMPTY_ID;
                slot_attr_reg[i]      <= '0;
                slot_countdown_reg[i] <= '0;
                slot_plane_lo_reg[i]  <= '0;
                slot_plane_hi_reg[i]  <= '0;
                slot_counting_reg[i]  <= 1'b0;
            end
        end else begin
            bg_plane_lo_reg    <= bg_plane_lo_next;
            bg_plane_hi_reg    <= bg_plane_hi_next;
            bg_attr_lo_reg     <= bg_attr_lo_next;
            bg_attr_hi_reg     <= bg_attr_hi_next;
            slot_id_reg        <= slot_id_next;
            slot_attr_reg      <= slot_attr_next;
            slot_countdown_reg <= slot_countdown_next;
            slot_plane_lo_reg  <= slot_plane_lo_next;
            slot_plane_hi_reg  <= slot_plane_hi_next;
            slot_counting_reg  <= slot_counting_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && produces) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produces) begin
            m_palette_address_reg <= addr_out;
            m_emphasis_bits_reg   <= emphasis_reg;
            m_sprite_zero_hit_reg <= hit;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_palette_address = m_palette_address_reg;
    assign m_emphasis_bits   = m_emphasis_bits_reg;
    assign m_sprite_zero_hit = m_sprite_zero_hit_reg;

endmodule

// ===== rtl/tpsc_checker.sv =====
// ============================================================================
// tpsc_checker
// Port-level checks for the tile/sprite pixel compositor.
// ============================================================================
module tpsc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_palette_address,
    input logic [2:0] m_emphasis_bits,
    input logic       m_sprite_zero_hit
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_palette_address)
            && $stable(m_emphasis_bits) && $stable(m_sprite_zero_hit))
        else $error("result beat changed while stalled");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a pending result");

    // a hit needs opaque background, so the chosen color is never transparent
    a_hit_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sprite_zero_hit |-> m_palette_address[1:0] != 2'd0)
        else $error("sprite zero hit on a transparent pixel");

    // first cycle after reset: empty output, input open
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind tile_pixel_sprite_compositor_top tpsc_checker u_tpsc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_palette_address (m_palette_address),
    .m_emphasis_bits   (m_emphasis_bits),
    .m_sprite_zero_hit (m_sprite_zero_hit)
);
